>>> sv/prf_pkg.sv
package prf_pkg;

    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int MAX_LENGTH_DEF    = 65535;

    localparam logic [16:0] TRIGGER_RST = 17'd16384;
    localparam logic [16:0] EDGE_RST    = 17'd6554;
    localparam logic [20:0] CLUSTER_RST = 21'd13107;

    // peak start value, -1.0 in Q16.16
    localparam logic signed [32:0] NO_COUNT = -33'sd65536;

    localparam logic [1:0] REG_TRIGGER = 2'd0;
    localparam logic [1:0] REG_EDGE    = 2'd1;
    localparam logic [1:0] REG_CLUSTER = 2'd2;

    localparam logic KIND_REGION  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // control from sequencer to the scan unit
    typedef struct packed {
        logic start;
        logic vld;
    } t_scan_ctl;

    function automatic logic [15:0] sat_bump(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

endpackage

>>> sv/prf_ram.sv
module prf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

>>> sv/prf_scan.sv
module prf_scan
    import prf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_scan_ctl                i_ctl,
    input  logic [31:0]              i_end_q,
    input  logic [31:0]              i_beg_q,
    input  logic [31:0]              i_base_e,
    input  logic [31:0]              i_top_b,
    output logic signed [32:0]       o_peak,
    output logic                     o_busy
);
    logic signed [32:0] w_left;
    logic signed [32:0] w_right;
    logic signed [32:0] r_x;
    logic               r_xv;
    logic signed [32:0] r_peak;

    // left and right expected counts, keep the smaller
    assign w_left  = $signed({1'b0, i_end_q}) - $signed({1'b0, i_base_e});
    assign w_right = $signed({1'b0, i_top_b}) - $signed({1'b0, i_beg_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
        end else begin
            r_xv <= i_ctl.vld;
        end
        r_x <= (w_left < w_right) ? w_left : w_right;
    end

    // running maximum
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_peak <= NO_COUNT;
        end else if (r_xv && (r_x > r_peak)) begin
            r_peak <= r_x;
        end
    end

    assign o_peak = r_peak;
    assign o_busy = r_xv;
endmodule

>>> sv/posterior_region_finder.sv
// An item that causes no result is accepted in S_IDLE and evaluated in S_EVAL.
// The input is stalled outside S_IDLE, so a new item waits until the last one is done; a summary adds S_SUMW.
// A region close that fits the history scans it through one read port per memory in S_BASE, S_SCAN,
// S_DRAIN and S_FIN before the region beat in S_RES; on the last item the summary beat follows.
// Reset is synchronous, active low: registers to defaults, counters and flags cleared;
// history entry 0 is cleared, the rest of the history memories are not.
module posterior_region_finder
    import prf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_begin_total,
    input  logic [31:0] i_end_total,
    input  logic [16:0] i_occupancy,
    input  logic        i_not_finite,
    input  logic        i_first,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [15:0] o_start_pos,
    output logic [15:0] o_end_pos,
    output logic        o_clustered,
    output logic [31:0] o_peak_expected,
    output logic        o_too_long,
    output logic [15:0] o_region_count,
    output logic [15:0] o_clustered_count,
    output logic [15:0] o_bad_count,
    output logic        o_open_at_end,
    output logic [31:0] o_terminal_gap,
    output logic        o_final_res
);
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [16:0]   DEPTH_LEN = 17'(HISTORY_DEPTH);
    localparam logic [15:0]   MAX_POS   = 16'(MAX_LENGTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVAL  = 8'b0000_0010,
        S_BASE  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_RES   = 8'b0100_0000,
        S_SUMW  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [16:0] r_trig, r_edge;
    logic [20:0] r_clus;

    logic [31:0] r_b, r_e;
    logic [16:0] r_occ;
    logic        r_nf, r_first, r_last;

    logic [15:0] r_pos, r_first_pos, r_j;
    logic        r_open, r_svalid;
    logic [31:0] r_prev_b, r_prev_e;
    logic [15:0] r_regions, r_clustered, r_skipped;
    logic [AW-1:0] r_wslot, r_sslot, r_ea, r_ba;
    logic [15:0] r_z;
    logic        r_rd_vld, r_base_pend;
    logic [31:0] r_base_e;

    logic               r_cl, r_tl;
    logic signed [31:0] r_pk;

    logic        r_ovld;
    logic        r_o_kind, r_o_cl, r_o_tl, r_o_oe, r_o_fin;
    logic [15:0] r_o_sp, r_o_ep, r_o_rc, r_o_cc, r_o_bc;
    logic [31:0] r_o_pk, r_o_gap;

    logic          w_acc, w_out_free, w_in_seq, w_close, w_move, w_long;
    logic [15:0]   w_j;
    logic [16:0]   w_len;
    logic [AW-1:0] w_nslot, w_sslot_m1;
    logic signed [34:0] w_bx, w_ex;
    logic signed [31:0] w_sat;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_eraddr;
    logic [31:0]   w_beg_wd, w_end_wd;
    logic [31:0]   w_end_q, w_beg_q;
    logic signed [32:0] w_peak;
    logic          w_busy;
    t_scan_ctl     w_ctl;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_ovld || !i_out_stall;

    // per-position decision terms
    assign w_in_seq   = (r_pos < MAX_POS);
    assign w_j        = r_pos + 16'd1;
    assign w_nslot    = (r_wslot == SLOT_LAST) ? '0 : r_wslot + AW'(1);
    assign w_sslot_m1 = (r_sslot == '0) ? SLOT_LAST : r_sslot - AW'(1);
    assign w_bx = $signed({18'b0, r_occ}) + $signed({3'b0, r_prev_b}) - $signed({3'b0, r_b});
    assign w_ex = $signed({18'b0, r_occ}) + $signed({3'b0, r_prev_e}) - $signed({3'b0, r_e});
    assign w_move  = (w_bx < $signed({18'b0, r_edge})) || !r_svalid;
    assign w_close = r_open && (w_ex < $signed({18'b0, r_edge}));
    assign w_len   = {1'b0, w_j} - {1'b0, r_first_pos} + 17'd1;
    assign w_long  = (w_len >= DEPTH_LEN);

    // clear history entry 0 during reset, else write in the evaluate cycle
    assign w_we     = !i_rst_n || ((r_state == S_EVAL) && (r_first || w_in_seq));
    assign w_waddr  = (!i_rst_n || r_first) ? '0 : w_nslot;
    assign w_beg_wd = i_rst_n ? r_b : '0;
    assign w_end_wd = i_rst_n ? r_e : '0;
    assign w_eraddr = (r_state == S_BASE) ? w_sslot_m1 : r_ea;

    prf_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_beg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_beg_wd),
        .i_raddr (r_ba),
        .o_rdata (w_beg_q)
    );

    prf_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_end_wd),
        .i_raddr (w_eraddr),
        .o_rdata (w_end_q)
    );

    assign w_ctl.start = (r_state == S_BASE);
    assign w_ctl.vld   = r_rd_vld;

    prf_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_end_q  (w_end_q),
        .i_beg_q  (w_beg_q),
        .i_base_e (r_base_e),
        .i_top_b  (r_b),
        .o_peak   (w_peak),
        .o_busy   (w_busy)
    );

    assign w_sat = (w_peak > 33'sd2147483647) ? 32'sh7FFF_FFFF : w_peak[31:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_acc) n_state = S_EVAL;
            S_EVAL: begin
                if (!r_first && w_in_seq && !r_nf && w_close) begin
                    n_state = w_long ? S_RES : S_BASE;
                end else if (r_last) begin
                    n_state = S_SUMW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BASE:  n_state = S_SCAN;
            S_SCAN:  if (r_z == r_j) n_state = S_DRAIN;
            S_DRAIN: if (!r_rd_vld && !w_busy) n_state = S_FIN;
            S_FIN:   n_state = S_RES;
            S_RES:   if (w_out_free) n_state = r_last ? S_SUMW : S_IDLE;
            S_SUMW:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_trig      <= TRIGGER_RST;
            r_edge      <= EDGE_RST;
            r_clus      <= CLUSTER_RST;
            r_pos       <= '0;
            r_open      <= 1'b0;
            r_svalid    <= 1'b0;
            r_first_pos <= '0;
            r_prev_b    <= '0;
            r_prev_e    <= '0;
            r_regions   <= '0;
            r_clustered <= '0;
            r_skipped   <= '0;
            r_wslot     <= '0;
            r_sslot     <= '0;
            r_rd_vld    <= 1'b0;
            r_base_pend <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= (r_state == S_SCAN);
            r_base_pend <= (r_state == S_BASE);

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TRIGGER: r_trig <= i_cfg_data[16:0];
                    REG_EDGE:    r_edge <= i_cfg_data[16:0];
                    REG_CLUSTER: r_clus <= i_cfg_data;
                    default:     ;
                endcase
            end

            // evaluate one position
            if (r_state == S_EVAL) begin
                if (r_first) begin
                    r_pos       <= '0;
                    r_open      <= 1'b0;
                    r_svalid    <= 1'b0;
                    r_first_pos <= '0;
                    r_regions   <= '0;
                    r_clustered <= '0;
                    r_skipped   <= '0;
                    r_prev_b    <= r_b;
                    r_prev_e    <= r_e;
                    r_wslot     <= '0;
                end else if (w_in_seq) begin
                    r_pos    <= w_j;
                    r_prev_b <= r_b;
                    r_prev_e <= r_e;
                    r_wslot  <= w_nslot;
                    if (r_nf) begin
                        r_skipped <= sat_bump(r_skipped);
                    end else if (!r_open) begin
                        if (w_move) begin
                            r_first_pos <= w_j;
                            r_sslot     <= w_nslot;
                            r_svalid    <= 1'b1;
                        end
                        if (r_occ >= r_trig) r_open <= 1'b1;
                    end else if (w_close && w_long) begin
                        r_regions <= sat_bump(r_regions);
                        r_open    <= 1'b0;
                        r_svalid  <= 1'b0;
                    end
                end
            end

            // close a scanned region
            if (r_state == S_FIN) begin
                r_regions <= sat_bump(r_regions);
                if ($signed(w_sat) >= $signed({11'b0, r_clus})) begin
                    r_clustered <= sat_bump(r_clustered);
                end
                r_open   <= 1'b0;
                r_svalid <= 1'b0;
            end

            // output beat valid
            if ((r_state == S_RES || r_state == S_SUMW) && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b     <= i_begin_total;
            r_e     <= i_end_total;
            r_occ   <= i_occupancy;
            r_nf    <= i_not_finite;
            r_first <= i_first;
            r_last  <= i_last;
        end

        // region result defaults for a region too long to scan
        if (r_state == S_EVAL) begin
            r_j  <= w_j;
            r_pk <= 32'(NO_COUNT);
            r_cl <= 1'b0;
            r_tl <= 1'b1;
        end

        // walk the history
        if (r_state == S_BASE) begin
            r_ea <= r_sslot;
            r_ba <= w_sslot_m1;
            r_z  <= r_first_pos;
        end
        if (r_state == S_SCAN) begin
            r_ea <= (r_ea == SLOT_LAST) ? '0 : r_ea + AW'(1);
            r_ba <= (r_ba == SLOT_LAST) ? '0 : r_ba + AW'(1);
            r_z  <= r_z + 16'd1;
        end
        if (r_base_pend) begin
            r_base_e <= w_end_q;
        end

        if (r_state == S_FIN) begin
            r_pk <= w_sat;
            r_cl <= ($signed(w_sat) >= $signed({11'b0, r_clus}));
            r_tl <= 1'b0;
        end

        // load the output beat
        if (r_state == S_RES && w_out_free) begin
            r_o_kind <= KIND_REGION;
            r_o_sp   <= r_first_pos;
            r_o_ep   <= r_j;
            r_o_cl   <= r_cl;
            r_o_pk   <= r_pk;
            r_o_tl   <= r_tl;
            r_o_rc   <= r_regions;
            r_o_cc   <= r_clustered;
            r_o_bc   <= r_skipped;
            r_o_oe   <= 1'b0;
            r_o_gap  <= '0;
            r_o_fin  <= !r_last;
        end else if (r_state == S_SUMW && w_out_free) begin
            r_o_kind <= KIND_SUMMARY;
            r_o_sp   <= '0;
            r_o_ep   <= r_pos;
            r_o_cl   <= 1'b0;
            r_o_pk   <= '0;
            r_o_tl   <= 1'b0;
            r_o_rc   <= r_regions;
            r_o_cc   <= r_clustered;
            r_o_bc   <= r_skipped;
            r_o_oe   <= r_open;
            r_o_gap  <= (r_prev_b >= r_prev_e) ? r_prev_b - r_prev_e : r_prev_e - r_prev_b;
            r_o_fin  <= 1'b1;
        end
    end

    assign o_out_valid       = r_ovld;
    assign o_kind            = r_o_kind;
    assign o_start_pos       = r_o_sp;
    assign o_end_pos         = r_o_ep;
    assign o_clustered       = r_o_cl;
    assign o_peak_expected   = r_o_pk;
    assign o_too_long        = r_o_tl;
    assign o_region_count    = r_o_rc;
    assign o_clustered_count = r_o_cc;
    assign o_bad_count       = r_o_bc;
    assign o_open_at_end     = r_o_oe;
    assign o_terminal_gap    = r_o_gap;
    assign o_final_res       = r_o_fin;

    // an accepted beat is evaluated in the next cycle
    a_acc_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_EVAL))
        else $error("accepted beat not evaluated");

    // the scanned peak never falls below its start value
    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (w_peak >= NO_COUNT))
        else $error("peak below start value");

    // clustered regions are a subset of closed regions
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clustered <= r_regions)
        else $error("clustered count exceeds region count");

    // a scan only runs on an open region
    a_scan_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BASE) |-> r_open)
        else $error("scan started without an open region");
endmodule

>>> dv/tb_top.sv
module tb_top;
    import prf_pkg::*;

    localparam int HIST      = HISTORY_DEPTH_DEF;
    localparam int MAX_POS   = MAX_LENGTH_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [31:0] begin_total;
        logic [31:0] end_total;
        logic [16:0] occupancy;
        logic        not_finite;
        logic        first;
        logic        last;
    } pos_beat_t;

    typedef struct {
        logic        kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic        clustered;
        logic [31:0] peak_expected;
        logic        too_long;
        logic [15:0] region_count;
        logic [15:0] clustered_count;
        logic [15:0] bad_count;
        logic        open_at_end;
        logic [31:0] terminal_gap;
        logic        final_res;
    } region_beat_t;

    // Region tracker mirror plus the queue of region/summary beats it predicts
    class region_scoreboard;
        logic [16:0] trig_lvl;
        logic [16:0] edge_lvl;
        logic [20:0] clus_lvl;
        int          cur_pos;
        bit          is_open;
        bit          have_start;
        int          open_pos;
        logic [31:0] last_begin;
        logic [31:0] last_end;
        logic [31:0] begin_mem [HIST];
        logic [31:0] end_mem [HIST];
        logic [15:0] n_regions;
        logic [15:0] n_clustered;
        logic [15:0] n_bad;
        region_beat_t pending_beats [$];
        int          errors;

        function new();
            trig_lvl    = TRIGGER_RST;
            edge_lvl    = EDGE_RST;
            clus_lvl    = CLUSTER_RST;
            cur_pos     = 0;
            is_open     = 0;
            have_start  = 0;
            open_pos    = 0;
            last_begin  = '0;
            last_end    = '0;
            n_regions   = '0;
            n_clustered = '0;
            n_bad       = '0;
            errors      = 0;
        endfunction

        function void set_level(logic [1:0] idx, logic [20:0] val);
            case (idx)
                REG_TRIGGER: trig_lvl = val[16:0];
                REG_EDGE:    edge_lvl = val[16:0];
                REG_CLUSTER: clus_lvl = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] sat_inc(logic [15:0] c);
            return (c == 16'hFFFF) ? c : c + 16'd1;
        endfunction

        // Advance the tracker by one accepted position beat
        function void note_position(pos_beat_t p);
            region_beat_t outs [2];
            region_beat_t r;
            int n;
            int j;
            int len;
            longint occ, bd, ed, peak, base_e, top_b, lft, rgt, x;
            bit tl, cl;
            n = 0;
            occ = longint'(p.occupancy);
            if (p.first) begin
                cur_pos = 0; is_open = 0; have_start = 0; open_pos = 0;
                n_regions = '0; n_clustered = '0; n_bad = '0;
                last_begin = p.begin_total;
                last_end   = p.end_total;
                begin_mem[0] = p.begin_total;
                end_mem[0]   = p.end_total;
            end else if (cur_pos < MAX_POS) begin
                j  = cur_pos + 1;
                bd = longint'(p.begin_total) - longint'(last_begin);
                ed = longint'(p.end_total) - longint'(last_end);
                cur_pos = j;
                begin_mem[j % HIST] = p.begin_total;
                end_mem[j % HIST]   = p.end_total;
                last_begin = p.begin_total;
                last_end   = p.end_total;
                if (p.not_finite) begin
                    n_bad = sat_inc(n_bad);
                end else if (!is_open) begin
                    if (occ - bd < longint'(edge_lvl) || !have_start) begin
                        open_pos   = j;
                        have_start = 1;
                    end
                    if (occ >= longint'(trig_lvl)) is_open = 1;
                end else if (occ - ed < longint'(edge_lvl)) begin
                    len  = j - open_pos + 1;
                    tl   = (len >= HIST);
                    peak = -65536;
                    cl   = 0;
                    if (!tl) begin
                        base_e = longint'(end_mem[(open_pos - 1) % HIST]);
                        top_b  = longint'(begin_mem[j % HIST]);
                        for (int z = open_pos; z <= j; z++) begin
                            lft = longint'(end_mem[z % HIST]) - base_e;
                            rgt = top_b - longint'(begin_mem[(z - 1) % HIST]);
                            x = (lft < rgt) ? lft : rgt;
                            if (x > peak) peak = x;
                        end
                        if (peak > 64'sd2147483647) peak = 64'sd2147483647;
                        if (peak < -64'sd2147483648) peak = -64'sd2147483648;
                        cl = (peak >= longint'(clus_lvl));
                    end
                    n_regions = sat_inc(n_regions);
                    if (cl) n_clustered = sat_inc(n_clustered);
                    is_open    = 0;
                    have_start = 0;
                    r = '{kind: KIND_REGION, start_pos: open_pos[15:0], end_pos: j[15:0],
                          clustered: cl, peak_expected: peak[31:0], too_long: tl,
                          region_count: n_regions, clustered_count: n_clustered,
                          bad_count: n_bad, open_at_end: 1'b0, terminal_gap: '0,
                          final_res: 1'b0};
                    outs[n] = r;
                    n++;
                end
            end
            if (p.last) begin
                r = '{kind: KIND_SUMMARY, start_pos: '0, end_pos: cur_pos[15:0],
                      clustered: 1'b0, peak_expected: '0, too_long: 1'b0,
                      region_count: n_regions, clustered_count: n_clustered,
                      bad_count: n_bad, open_at_end: is_open,
                      terminal_gap: (last_begin >= last_end) ? last_begin - last_end
                                                             : last_end - last_begin,
                      final_res: 1'b0};
                outs[n] = r;
                n++;
            end
            for (int k = 0; k < n; k++) begin
                if (k == n - 1) outs[k].final_res = 1'b1;
                pending_beats.push_back(outs[k]);
            end
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted output beat against the oldest prediction
        function void check_beat(region_beat_t a);
            region_beat_t e;
            if (pending_beats.size() == 0) begin
                $error("unexpected output beat, kind %0d end_pos %0d", a.kind, a.end_pos);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            cmp("kind", 32'(e.kind), 32'(a.kind));
            cmp("start_pos", 32'(e.start_pos), 32'(a.start_pos));
            cmp("end_pos", 32'(e.end_pos), 32'(a.end_pos));
            cmp("clustered", 32'(e.clustered), 32'(a.clustered));
            cmp("peak_expected", e.peak_expected, a.peak_expected);
            cmp("too_long", 32'(e.too_long), 32'(a.too_long));
            cmp("region_count", 32'(e.region_count), 32'(a.region_count));
            cmp("clustered_count", 32'(e.clustered_count), 32'(a.clustered_count));
            cmp("bad_count", 32'(e.bad_count), 32'(a.bad_count));
            cmp("open_at_end", 32'(e.open_at_end), 32'(a.open_at_end));
            cmp("terminal_gap", e.terminal_gap, a.terminal_gap);
            cmp("final_res", 32'(e.final_res), 32'(a.final_res));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [20:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_begin_total;
    logic [31:0] i_end_total;
    logic [16:0] i_occupancy;
    logic        i_not_finite;
    logic        i_first;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_kind;
    logic [15:0] o_start_pos;
    logic [15:0] o_end_pos;
    logic        o_clustered;
    logic [31:0] o_peak_expected;
    logic        o_too_long;
    logic [15:0] o_region_count;
    logic [15:0] o_clustered_count;
    logic [15:0] o_bad_count;
    logic        o_open_at_end;
    logic [31:0] o_terminal_gap;
    logic        o_final_res;

    region_scoreboard sb;
    int  burst_left;
    bit  no_gaps;
    int  stall_mode;
    int  stall_hold;
    int  idle_cycles;

    posterior_region_finder u_dut (.*);

    // Clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Receiver: check accepted beats, stall on a pattern that changes mode
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_beat('{o_kind, o_start_pos, o_end_pos, o_clustered, o_peak_expected,
                            o_too_long, o_region_count, o_clustered_count, o_bad_count,
                            o_open_at_end, o_terminal_gap, o_final_res});
        end
        if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_hold = $urandom_range(20, 200);
        end else begin
            stall_hold--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            2:       i_out_stall <= (stall_hold % 16) < 11;
            default: i_out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: count cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("posterior_region_finder test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one position beat and hold it until accepted
    task automatic send_pos(pos_beat_t p);
        int gap;
        i_in_valid    <= 1'b1;
        i_begin_total <= p.begin_total;
        i_end_total   <= p.end_total;
        i_occupancy   <= p.occupancy;
        i_not_finite  <= p.not_finite;
        i_first       <= p.first;
        i_last        <= p.last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_position(p);
        if (!no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_fields(logic [31:0] b, logic [31:0] e, logic [16:0] occ,
                               logic nf, logic fi, logic la);
        pos_beat_t p;
        p = '{b, e, occ, nf, fi, la};
        send_pos(p);
    endtask

    // Drop valid and wait until every predicted beat has drained
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_beats.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_levels(logic [16:0] trig, logic [16:0] edg, logic [20:0] clus);
        logic [20:0] vals [3];
        vals = '{{4'd0, trig}, {4'd0, edg}, clus};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k[1:0];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_level(k[1:0], vals[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One well-formed sequence: occupancy alternates high and low runs
    task automatic run_sequence(int len);
        logic [31:0] b, e;
        logic [16:0] occ;
        int  run;
        bit  high;
        b = $urandom();
        e = $urandom();
        if ($urandom_range(0, 3) == 0) begin
            b = '0;
            e = '0;
        end
        send_fields(b, e, 17'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)), 1'b1,
                    len == 0);
        run  = 0;
        high = 0;
        for (int k = 1; k <= len; k++) begin
            if (run == 0) begin
                high = !high;
                run  = $urandom_range(1, 3);
            end
            run--;
            occ = high ? 17'($urandom_range(30000, 65536)) : 17'($urandom_range(0, 20000));
            if ($urandom_range(0, 15) == 0) begin
                b = $urandom();
                e = $urandom();
            end else begin
                b = b + $urandom_range(0, 'h18000);
                e = e + $urandom_range(0, 'h18000);
            end
            send_fields(b, e, occ, $urandom_range(0, 19) == 0, 1'b0, k == len);
        end
    endtask

    // Broken traffic: fully random fields, first/last anywhere
    task automatic run_noise(int cnt);
        for (int k = 0; k < cnt; k++) begin
            send_fields($urandom(), $urandom(), 17'($urandom_range(0, 65536)),
                        1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                        $urandom_range(0, 5) == 0);
        end
    endtask

    initial begin
        logic [31:0] b;
        int sent;
        int seq_len;
        sb          = new();
        burst_left  = 0;
        no_gaps     = 0;
        stall_mode  = 0;
        stall_hold  = 0;
        idle_cycles = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_TRIGGER;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_begin_total = '0;
        i_end_total   = '0;
        i_occupancy   = '0;
        i_not_finite  = 1'b0;
        i_first       = 1'b0;
        i_last        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults; non-finite on first, open/close, non-finite mid-region
        send_fields(32'h0, 32'h0, 17'd0, 1'b1, 1'b1, 1'b0);
        send_fields(32'h10000, 32'h0, 17'd65536, 1'b0, 1'b0, 1'b0);
        send_fields(32'h20000, 32'h8000, 17'd65536, 1'b1, 1'b0, 1'b0);
        send_fields(32'h28000, 32'h30000, 17'd0, 1'b0, 1'b0, 1'b1);
        // Expected counts far below the peak start value: totals fall from the top
        send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, 17'd0, 1'b0, 1'b1, 1'b0);
        send_fields(32'h0, 32'h0, 17'd65536, 1'b0, 1'b0, 1'b0);
        send_fields(32'h0, 32'h0, 17'd0, 1'b0, 1'b0, 1'b1);
        // Peak saturating high, region still open at the summary
        send_fields(32'h0, 32'h0, 17'd0, 1'b0, 1'b1, 1'b0);
        send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, 17'd65536, 1'b0, 1'b0, 1'b0);
        send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, 17'd0, 1'b0, 1'b0, 1'b0);
        send_fields(32'hFFFFFFFF, 32'h0, 17'd65536, 1'b0, 1'b0, 1'b1);
        // First and last together
        send_fields(32'h5555AAAA, 32'hAAAA5555, 17'd65536, 1'b1, 1'b1, 1'b1);
        // Region exactly as long as the history
        send_fields(32'h0, 32'h0, 17'd0, 1'b0, 1'b1, 1'b0);
        b = '0;
        for (int k = 1; k <= HIST; k++) begin
            b = b + 32'h100;
            send_fields(b, 32'h0, (k == HIST) ? 17'd0 : 17'd65536, 1'b0, 1'b0,
                        k == HIST);
        end
        drain();

        // Random phases across register settings, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_levels(17'd0, 17'd0, 21'd0);
                1: set_levels(17'd65536, 17'd65536, 21'd1048576);
                2: set_levels(17'd65536, 17'd0, 21'd0);
                3: set_levels(17'd0, 17'd65536, 21'd1048576);
                4: set_levels(TRIGGER_RST, EDGE_RST, CLUSTER_RST);
                default: set_levels(17'($urandom_range(0, 65536)),
                                    17'($urandom_range(0, 65536)),
                                    21'($urandom_range(0, 1048576)));
            endcase
            sent = 0;
            while (sent < 6) begin
                if ($urandom_range(0, 5) == 0) begin
                    run_noise(3);
                    sent += 3;
                end else begin
                    seq_len = $urandom_range(0, 6);
                    run_sequence(seq_len);
                    sent += seq_len + 1;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("posterior_region_finder test passed");
        end else begin
            $display("posterior_region_finder test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/prf_pkg.sv
sv/prf_ram.sv
sv/prf_scan.sv
sv/posterior_region_finder.sv
dv/tb_top.sv
